FILE: rtl/core/npc_pkg.sv
`timescale 1ns / 1ps

package npc_pkg;

  localparam int POS_W  = 24;
  localparam int EXT_W  = 20;
  localparam int SUM_W  = EXT_W + 1;
  localparam int DIF_W  = POS_W + 1;
  localparam int GEO_W  = POS_W + 2;
  localparam int MAG_W  = GEO_W - 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int D2_W   = SQ_W + 2;
  localparam int DIST_W = D2_W / 2;
  localparam int NRM_W  = 16;
  localparam int PEN_W  = 21;
  localparam int FRAC_W = 14;
  localparam int QUO_W  = FRAC_W + 1;
  localparam int NUM_W  = DIST_W + FRAC_W;

  localparam logic SHAPE_SPHERE = 1'b1;

  localparam logic signed [NRM_W-1:0] NRM_ONE  = 16'sd16384;
  localparam logic signed [NRM_W-1:0] NRM_MONE = -16'sd16384;

  typedef struct packed {
    logic                    shape_a;
    logic                    shape_b;
    logic                    trigger_a;
    logic                    trigger_b;
    logic signed [POS_W-1:0] a_pos_x;
    logic signed [POS_W-1:0] a_pos_y;
    logic signed [POS_W-1:0] a_pos_z;
    logic signed [POS_W-1:0] b_pos_x;
    logic signed [POS_W-1:0] b_pos_y;
    logic signed [POS_W-1:0] b_pos_z;
    logic [3*EXT_W-1:0]      a_extents;
    logic [3*EXT_W-1:0]      b_extents;
  } in_beat_t;

  typedef struct packed {
    logic                    contact;
    logic                    solid_contact;
    logic                    trigger_a_fires;
    logic                    trigger_b_fires;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic [PEN_W-1:0]        penetration;
  } out_beat_t;

  // per-pair data carried alongside the distance path
  typedef struct packed {
    logic                        hit;
    logic                        solid;
    logic                        tfa;
    logic                        tfb;
    logic                        use_div;
    logic [2:0]                  neg;
    logic [2:0][MAG_W-1:0]       mag;
    logic [2:0][NRM_W-1:0]       nrm;
    logic [PEN_W-1:0]            pen;
    logic [PEN_W-1:0]            rad;
  } side_t;

endpackage

FILE: rtl/core/npc_front.sv
`timescale 1ns / 1ps

module npc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  npc_pkg::in_beat_t           beat_i,
  output logic                        vld_o,
  output logic [npc_pkg::D2_W-1:0]    d2_o,
  output npc_pkg::side_t              side_o
);

  localparam int POSW = npc_pkg::POS_W;
  localparam int EXTW = npc_pkg::EXT_W;
  localparam int SUMW = npc_pkg::SUM_W;
  localparam int DIFW = npc_pkg::DIF_W;
  localparam int GEOW = npc_pkg::GEO_W;
  localparam int MAGW = npc_pkg::MAG_W;
  localparam int SQW  = npc_pkg::SQ_W;
  localparam int D2W  = npc_pkg::D2_W;
  localparam int PENW = npc_pkg::PEN_W;
  localparam int NRMW = npc_pkg::NRM_W;

  localparam logic [NRMW-1:0] NRM_ONE_U  = npc_pkg::NRM_ONE;
  localparam logic [NRMW-1:0] NRM_MONE_U = npc_pkg::NRM_MONE;

  logic [5:0] v_r;

  // stage 0: input beat
  npc_pkg::in_beat_t s0_r;

  // stage 1: differences, box bounds, extent sums
  logic signed [POSW-1:0] s1_sph_r [3];
  logic signed [GEOW-1:0] s1_lo_r  [3];
  logic signed [GEOW-1:0] s1_hi_r  [3];
  logic signed [DIFW-1:0] s1_dd_r  [3];
  logic [SUMW-1:0]        s1_esum_r[3];
  logic [PENW-1:0]        s1_rad_r;
  logic                   s1_ss_r, s1_bb_r, s1_asb_r, s1_ta_r, s1_tb_r;

  logic signed [POSW-1:0] s1_sph_nxt [3];
  logic signed [GEOW-1:0] s1_lo_nxt  [3];
  logic signed [GEOW-1:0] s1_hi_nxt  [3];
  logic signed [DIFW-1:0] s1_dd_nxt  [3];
  logic [SUMW-1:0]        s1_esum_nxt[3];
  logic [PENW-1:0]        s1_rad_nxt;

  always_comb begin
    logic sa, sb;
    logic signed [POSW-1:0] pa, pb, cc;
    logic [EXTW-1:0] ha, hb, ea, eb, hh;
    sa = s0_r.shape_a == npc_pkg::SHAPE_SPHERE;
    sb = s0_r.shape_b == npc_pkg::SHAPE_SPHERE;
    for (int i = 0; i < 3; i++) begin
      case (i)
        0: begin
          pa = s0_r.a_pos_x;
          pb = s0_r.b_pos_x;
        end
        1: begin
          pa = s0_r.a_pos_y;
          pb = s0_r.b_pos_y;
        end
        default: begin
          pa = s0_r.a_pos_z;
          pb = s0_r.b_pos_z;
        end
      endcase
      ha = s0_r.a_extents[EXTW*i +: EXTW];
      hb = s0_r.b_extents[EXTW*i +: EXTW];
      ea = sa ? s0_r.a_extents[EXTW-1:0] : ha;
      eb = sb ? s0_r.b_extents[EXTW-1:0] : hb;
      s1_dd_nxt[i]   = DIFW'(pb) - DIFW'(pa);
      s1_esum_nxt[i] = {1'b0, ea} + {1'b0, eb};
      s1_sph_nxt[i]  = sa ? pa : pb;
      cc             = sa ? pb : pa;
      hh             = sa ? hb : ha;
      s1_lo_nxt[i]   = GEOW'(cc) - $signed({{(GEOW-EXTW){1'b0}}, hh});
      s1_hi_nxt[i]   = GEOW'(cc) + $signed({{(GEOW-EXTW){1'b0}}, hh});
    end
    if (sa && sb) begin
      s1_rad_nxt = {1'b0, s0_r.a_extents[EXTW-1:0]} + {1'b0, s0_r.b_extents[EXTW-1:0]};
    end else if (sa) begin
      s1_rad_nxt = {1'b0, s0_r.a_extents[EXTW-1:0]};
    end else begin
      s1_rad_nxt = {1'b0, s0_r.b_extents[EXTW-1:0]};
    end
  end

  // stage 2: closest point vector and overlaps
  logic signed [GEOW-1:0] s2_w_r  [3];
  logic signed [GEOW-1:0] s2_ov_r [3];
  logic [2:0]             s2_pos_r;
  logic [PENW-1:0]        s2_rad_r;
  logic                   s2_ss_r, s2_bb_r, s2_ta_r, s2_tb_r;

  logic signed [GEOW-1:0] s2_w_nxt  [3];
  logic signed [GEOW-1:0] s2_ov_nxt [3];
  logic [2:0]             s2_pos_nxt;

  always_comb begin
    logic signed [GEOW-1:0] s26, pp, uu;
    logic [DIFW-1:0] adx;
    for (int i = 0; i < 3; i++) begin
      s26 = GEOW'(s1_sph_r[i]);
      if (s26 < s1_lo_r[i]) begin
        pp = s1_lo_r[i];
      end else if (s26 > s1_hi_r[i]) begin
        pp = s1_hi_r[i];
      end else begin
        pp = s26;
      end
      uu = pp - s26;
      if (s1_ss_r) begin
        s2_w_nxt[i] = GEOW'(s1_dd_r[i]);
      end else begin
        s2_w_nxt[i] = s1_asb_r ? uu : -uu;
      end
      adx = s1_dd_r[i][DIFW-1] ? DIFW'(-s1_dd_r[i]) : DIFW'(s1_dd_r[i]);
      s2_ov_nxt[i] = $signed({{(GEOW-SUMW){1'b0}}, s1_esum_r[i]})
                   - $signed({{(GEOW-DIFW){1'b0}}, adx});
      s2_pos_nxt[i] = (s1_dd_r[i] > 0) || ((s1_dd_r[i] == 0) && !s1_asb_r);
    end
  end

  // stage 3: squares, radius square, least overlap axis
  logic [SQW-1:0]         s3_sq_r [3];
  logic [2*PENW-1:0]      s3_rsq_r;
  logic [2:0]             s3_neg_r;
  logic [2:0][MAGW-1:0]   s3_mag_r;
  logic [2:0][NRMW-1:0]   s3_nls_r;
  logic [PENW-1:0]        s3_pls_r;
  logic [PENW-1:0]        s3_rad_r;
  logic                   s3_bbhit_r, s3_ss_r, s3_bb_r, s3_ta_r, s3_tb_r;

  logic [SQW-1:0]         s3_sq_nxt [3];
  logic [2:0]             s3_neg_nxt;
  logic [2:0][MAGW-1:0]   s3_mag_nxt;
  logic [2:0][NRMW-1:0]   s3_nls_nxt;
  logic [PENW-1:0]        s3_pls_nxt;
  logic                   s3_bbhit_nxt;

  always_comb begin
    logic [GEOW-1:0] aw;
    logic [1:0] k;
    s3_bbhit_nxt = 1'b1;
    for (int i = 0; i < 3; i++) begin
      aw = s2_w_r[i][GEOW-1] ? GEOW'(-s2_w_r[i]) : GEOW'(s2_w_r[i]);
      s3_mag_nxt[i] = aw[MAGW-1:0];
      s3_neg_nxt[i] = s2_w_r[i][GEOW-1];
      s3_sq_nxt[i]  = SQW'(aw[MAGW-1:0]) * SQW'(aw[MAGW-1:0]);
      if (s2_ov_r[i] <= 0) begin
        s3_bbhit_nxt = 1'b0;
      end
    end
    k = 2'd0;
    if (s2_ov_r[1] < s2_ov_r[0]) begin
      k = 2'd1;
    end
    if (s2_ov_r[2] < s2_ov_r[k]) begin
      k = 2'd2;
    end
    s3_nls_nxt    = '0;
    s3_nls_nxt[k] = s2_pos_r[k] ? NRM_ONE_U : NRM_MONE_U;
    s3_pls_nxt    = s2_ov_r[k][PENW-1:0];
  end

  // stage 4: squared distance
  logic [D2W-1:0]         s4_d2_r;
  logic [2*PENW-1:0]      s4_rsq_r;
  logic [2:0]             s4_neg_r;
  logic [2:0][MAGW-1:0]   s4_mag_r;
  logic [2:0][NRMW-1:0]   s4_nls_r;
  logic [PENW-1:0]        s4_pls_r;
  logic [PENW-1:0]        s4_rad_r;
  logic                   s4_bbhit_r, s4_ss_r, s4_bb_r, s4_ta_r, s4_tb_r;

  // stage 5: contact decision
  logic [D2W-1:0]         s5_d2_r;
  npc_pkg::side_t         s5_side_r;
  npc_pkg::side_t         s5_side_nxt;

  always_comb begin
    logic hit, d2z;
    d2z = s4_d2_r == '0;
    if (s4_bb_r) begin
      hit = s4_bbhit_r;
    end else if (s4_ss_r) begin
      hit = s4_d2_r < D2W'(s4_rsq_r);
    end else begin
      hit = s4_d2_r <= D2W'(s4_rsq_r);
    end
    s5_side_nxt.hit     = hit;
    s5_side_nxt.solid   = hit && !s4_ta_r && !s4_tb_r;
    s5_side_nxt.tfa     = hit && s4_ta_r;
    s5_side_nxt.tfb     = hit && s4_tb_r;
    s5_side_nxt.use_div = hit && !s4_bb_r && !d2z;
    s5_side_nxt.neg     = s4_neg_r;
    s5_side_nxt.mag     = s4_mag_r;
    s5_side_nxt.rad     = s4_rad_r;
    s5_side_nxt.nrm     = '0;
    s5_side_nxt.pen     = '0;
    if (hit && (s4_bb_r || (!s4_ss_r && d2z))) begin
      s5_side_nxt.nrm = s4_nls_r;
      s5_side_nxt.pen = s4_pls_r;
    end else if (hit && s4_ss_r && d2z) begin
      s5_side_nxt.nrm[0] = NRM_ONE_U;
      s5_side_nxt.pen    = s4_rad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= beat_i;

      s1_sph_r  <= s1_sph_nxt;
      s1_lo_r   <= s1_lo_nxt;
      s1_hi_r   <= s1_hi_nxt;
      s1_dd_r   <= s1_dd_nxt;
      s1_esum_r <= s1_esum_nxt;
      s1_rad_r  <= s1_rad_nxt;
      s1_ss_r   <= (s0_r.shape_a == npc_pkg::SHAPE_SPHERE)
                && (s0_r.shape_b == npc_pkg::SHAPE_SPHERE);
      s1_bb_r   <= (s0_r.shape_a != npc_pkg::SHAPE_SPHERE)
                && (s0_r.shape_b != npc_pkg::SHAPE_SPHERE);
      s1_asb_r  <= (s0_r.shape_a == npc_pkg::SHAPE_SPHERE)
                && (s0_r.shape_b != npc_pkg::SHAPE_SPHERE);
      s1_ta_r   <= s0_r.trigger_a;
      s1_tb_r   <= s0_r.trigger_b;

      s2_w_r   <= s2_w_nxt;
      s2_ov_r  <= s2_ov_nxt;
      s2_pos_r <= s2_pos_nxt;
      s2_rad_r <= s1_rad_r;
      s2_ss_r  <= s1_ss_r;
      s2_bb_r  <= s1_bb_r;
      s2_ta_r  <= s1_ta_r;
      s2_tb_r  <= s1_tb_r;

      s3_sq_r    <= s3_sq_nxt;
      s3_rsq_r   <= (2*PENW)'(s2_rad_r) * (2*PENW)'(s2_rad_r);
      s3_neg_r   <= s3_neg_nxt;
      s3_mag_r   <= s3_mag_nxt;
      s3_nls_r   <= s3_nls_nxt;
      s3_pls_r   <= s3_pls_nxt;
      s3_rad_r   <= s2_rad_r;
      s3_bbhit_r <= s3_bbhit_nxt;
      s3_ss_r    <= s2_ss_r;
      s3_bb_r    <= s2_bb_r;
      s3_ta_r    <= s2_ta_r;
      s3_tb_r    <= s2_tb_r;

      s4_d2_r    <= D2W'(s3_sq_r[0]) + D2W'(s3_sq_r[1]) + D2W'(s3_sq_r[2]);
      s4_rsq_r   <= s3_rsq_r;
      s4_neg_r   <= s3_neg_r;
      s4_mag_r   <= s3_mag_r;
      s4_nls_r   <= s3_nls_r;
      s4_pls_r   <= s3_pls_r;
      s4_rad_r   <= s3_rad_r;
      s4_bbhit_r <= s3_bbhit_r;
      s4_ss_r    <= s3_ss_r;
      s4_bb_r    <= s3_bb_r;
      s4_ta_r    <= s3_ta_r;
      s4_tb_r    <= s3_tb_r;

      s5_d2_r   <= s4_d2_r;
      s5_side_r <= s5_side_nxt;
    end
  end

  assign vld_o  = v_r[5];
  assign d2_o   = s5_d2_r;
  assign side_o = s5_side_r;

endmodule

FILE: rtl/core/npc_sqrt.sv
`timescale 1ns / 1ps

module npc_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [npc_pkg::D2_W-1:0]    d2_i,
  input  npc_pkg::side_t              side_i,
  output logic                        vld_o,
  output logic [npc_pkg::DIST_W-1:0]  dist_o,
  output npc_pkg::side_t              side_o
);

  localparam int D2W   = npc_pkg::D2_W;
  localparam int STEPS = npc_pkg::DIST_W;

  logic [D2W-1:0]  rem_r  [STEPS];
  logic [D2W-1:0]  root_r [STEPS];
  npc_pkg::side_t  side_r [STEPS];
  logic [STEPS-1:0] vld_r;

  // one result bit per stage, digit-by-digit square root
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [D2W-1:0] rem_in, root_in, bit_v, trial, rem_nxt, root_nxt;
    npc_pkg::side_t side_in;
    logic           vld_in;

    if (k == 0) begin : g_first
      assign rem_in  = d2_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    assign bit_v = {{(D2W-1){1'b0}}, 1'b1} << (2 * (STEPS - 1 - k));
    assign trial = root_in + bit_v;

    always_comb begin
      if (rem_in >= trial) begin
        rem_nxt  = rem_in - trial;
        root_nxt = (root_in >> 1) + bit_v;
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[STEPS-1];
  assign dist_o = root_r[STEPS-1][STEPS-1:0];
  assign side_o = side_r[STEPS-1];

endmodule

FILE: rtl/core/npc_div.sv
`timescale 1ns / 1ps

module npc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [npc_pkg::DIST_W-1:0]  dist_i,
  input  npc_pkg::side_t              side_i,
  output logic                        vld_o,
  output npc_pkg::out_beat_t          beat_o
);

  localparam int DISTW = npc_pkg::DIST_W;
  localparam int NUMW  = npc_pkg::NUM_W;
  localparam int QUOW  = npc_pkg::QUO_W;
  localparam int FRACW = npc_pkg::FRAC_W;
  localparam int PENW  = npc_pkg::PEN_W;
  localparam int NRMW  = npc_pkg::NRM_W;

  // entry: rounded numerators and sphere penetration
  logic [NUMW-1:0]  e_num_r [3];
  logic [DISTW-1:0] e_dist_r;
  npc_pkg::side_t   e_side_r;
  logic             e_vld_r;
  npc_pkg::side_t   e_side_nxt;
  logic [DISTW-1:0] pen_full;

  always_comb begin
    pen_full   = DISTW'(side_i.rad) - dist_i;
    e_side_nxt = side_i;
    if (side_i.use_div) begin
      e_side_nxt.pen = pen_full[PENW-1:0];
    end
  end

  logic [NUMW-1:0]  rem_r  [QUOW][3];
  logic [QUOW-1:0]  quo_r  [QUOW][3];
  logic [DISTW-1:0] dist_r [QUOW];
  npc_pkg::side_t   side_r [QUOW];
  logic [QUOW-1:0]  vld_r;

  // restoring division, one quotient bit per stage on three lanes
  for (genvar j = 0; j < QUOW; j++) begin : g_step
    logic [NUMW-1:0]  rem_in [3];
    logic [QUOW-1:0]  quo_in [3];
    logic [NUMW-1:0]  rem_nxt [3];
    logic [QUOW-1:0]  quo_nxt [3];
    logic [DISTW-1:0] dist_in;
    logic [NUMW-1:0]  dsh;
    npc_pkg::side_t   side_in;
    logic             vld_in;

    if (j == 0) begin : g_first
      assign rem_in  = e_num_r;
      assign quo_in  = '{default: '0};
      assign dist_in = e_dist_r;
      assign side_in = e_side_r;
      assign vld_in  = e_vld_r;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign quo_in  = quo_r[j-1];
      assign dist_in = dist_r[j-1];
      assign side_in = side_r[j-1];
      assign vld_in  = vld_r[j-1];
    end

    assign dsh = NUMW'(dist_in) << (QUOW - 1 - j);

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        quo_nxt[i] = quo_in[i];
        if (rem_in[i] >= dsh) begin
          rem_nxt[i] = rem_in[i] - dsh;
          quo_nxt[i][QUOW-1-j] = 1'b1;
        end else begin
          rem_nxt[i] = rem_in[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        quo_r[j]  <= quo_nxt;
        dist_r[j] <= dist_in;
        side_r[j] <= side_in;
      end
    end
  end

  // final sign and result assembly
  npc_pkg::side_t      ls;
  npc_pkg::out_beat_t  out_r, out_nxt;
  logic                out_vld_r;
  logic [NRMW-1:0]     nv [3];

  assign ls = side_r[QUOW-1];

  always_comb begin
    logic [NRMW-1:0] q16;
    for (int i = 0; i < 3; i++) begin
      q16 = {1'b0, quo_r[QUOW-1][i]};
      if (ls.use_div) begin
        nv[i] = ls.neg[i] ? NRMW'(-q16) : q16;
      end else begin
        nv[i] = ls.nrm[i];
      end
    end
    out_nxt.contact         = ls.hit;
    out_nxt.solid_contact   = ls.solid;
    out_nxt.trigger_a_fires = ls.tfa;
    out_nxt.trigger_b_fires = ls.tfb;
    out_nxt.normal_x        = $signed(nv[0]);
    out_nxt.normal_y        = $signed(nv[1]);
    out_nxt.normal_z        = $signed(nv[2]);
    out_nxt.penetration     = ls.pen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r   <= vld_i;
      out_vld_r <= vld_r[QUOW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e_num_r[i] <= NUMW'({side_i.mag[i], {FRACW{1'b0}}}) + NUMW'(dist_i >> 1);
      end
      e_dist_r <= dist_i;
      e_side_r <= e_side_nxt;
      out_r    <= out_nxt;
    end
  end

  assign vld_o  = out_vld_r;
  assign beat_o = out_r;

endmodule

FILE: rtl/core/narrow_phase_contact_test.sv
`timescale 1ns / 1ps

// narrow-phase contact test for one box or sphere pair per beat. a new pair is
// taken every cycle while the pipe is not frozen, and passes through 6 stages
// of geometry (input register, differences, closest point, squares, squared
// distance, contact decision), 26 stages of the square root (one root bit per
// stage) and 17 stages for the normal (entry, 15 restoring divide stages on
// three lanes, output register). the whole pipe freezes while out_stall holds a
// waiting result, so in_stall follows out_stall while out_valid is high, and
// in_stall is also high during reset. positions are Q13.10, extents Q10.10,
// normals Q1.14 from A toward B, penetration Q11.10.
module narrow_phase_contact_test (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  npc_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output npc_pkg::out_beat_t  out_beat
);

  logic                        en;
  logic                        fr_vld, sq_vld;
  logic [npc_pkg::D2_W-1:0]    fr_d2;
  logic [npc_pkg::DIST_W-1:0]  sq_dist;
  npc_pkg::side_t              fr_side, sq_side;

  // global advance: hold everything only while a result waits at the output
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en || !rst_n;

  // geometry front: squared distance, box overlaps, contact decision
  npc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid),
    .beat_i (in_beat),
    .vld_o  (fr_vld),
    .d2_o   (fr_d2),
    .side_o (fr_side)
  );

  // floor square root of the squared distance
  npc_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (fr_vld),
    .d2_i   (fr_d2),
    .side_i (fr_side),
    .vld_o  (sq_vld),
    .dist_o (sq_dist),
    .side_o (sq_side)
  );

  // normal components by rounded division, result beat register
  npc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (sq_vld),
    .dist_i (sq_dist),
    .side_i (sq_side),
    .vld_o  (out_valid),
    .beat_o (out_beat)
  );

endmodule

FILE: test/narrow_phase_contact_test_tb.sv
`timescale 1ns / 1ps

module narrow_phase_contact_test_tb;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  npc_pkg::in_beat_t  in_beat;
  logic               out_valid;
  logic               out_stall;
  npc_pkg::out_beat_t out_beat;

  narrow_phase_contact_test uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat)
  );

  npc_pkg::out_beat_t contact_q[$];
  int unsigned errors = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned hits_seen = 0;
  int unsigned hold_cycles = 0;   // long receiver hold-off when nonzero
  bit          quiet_out = 0;     // receiver never stalls when set

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("timeout at %0t", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint ext_of(logic [3*npc_pkg::EXT_W-1:0] e, int i);
    return longint'(e[20*i +: 20]);
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r = 0;
    longint b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // rounded unit-vector component scaled to Q1.14
  function automatic longint unit_comp(longint c, longint dlen);
    longint q;
    q = (labs(c) * 16384 + dlen / 2) / dlen;
    return c < 0 ? -q : q;
  endfunction

  function automatic npc_pkg::out_beat_t predict_contact(npc_pkg::in_beat_t b);
    npc_pkg::out_beat_t r;
    longint pa[3], pb[3], ha[3], hb[3], n[3], d[3], ov[3];
    longint s[3], c[3], h[3], v[3];
    longint pen, d2, dlen, rad, rs, lo, hi, p;
    bit hit, flip, neg_dir;
    int k;
    pa[0] = b.a_pos_x; pa[1] = b.a_pos_y; pa[2] = b.a_pos_z;
    pb[0] = b.b_pos_x; pb[1] = b.b_pos_y; pb[2] = b.b_pos_z;
    for (int i = 0; i < 3; i++) begin
      ha[i] = ext_of(b.a_extents, i);
      hb[i] = ext_of(b.b_extents, i);
      n[i] = 0;
    end
    pen = 0;
    hit = 0;
    flip = 0;
    if (b.shape_a != npc_pkg::SHAPE_SPHERE && b.shape_b != npc_pkg::SHAPE_SPHERE) begin
      // box/box: least overlap axis, strict overlap on every axis
      hit = 1;
      for (int i = 0; i < 3; i++) begin
        d[i] = pb[i] - pa[i];
        ov[i] = ha[i] + hb[i] - labs(d[i]);
        if (ov[i] <= 0) hit = 0;
      end
      if (hit) begin
        k = 0;
        for (int i = 1; i < 3; i++) if (ov[i] < ov[k]) k = i;
        n[k] = d[k] < 0 ? -16384 : 16384;
        pen = ov[k];
      end
    end else if (b.shape_a == npc_pkg::SHAPE_SPHERE &&
                 b.shape_b == npc_pkg::SHAPE_SPHERE) begin
      // sphere/sphere: touching is no contact, coincident gives +x
      d2 = 0;
      rs = ha[0] + hb[0];
      for (int i = 0; i < 3; i++) begin
        d[i] = pb[i] - pa[i];
        d2 += d[i] * d[i];
      end
      if (d2 < rs * rs) begin
        hit = 1;
        dlen = int_sqrt(d2);
        if (d2 == 0) n[0] = 16384;
        else for (int i = 0; i < 3; i++) n[i] = unit_comp(d[i], dlen);
        pen = rs - dlen;
      end
    end else begin
      // sphere/box, swapped and negated when A is the box
      flip = (b.shape_a != npc_pkg::SHAPE_SPHERE);
      for (int i = 0; i < 3; i++) begin
        s[i] = flip ? pb[i] : pa[i];
        c[i] = flip ? pa[i] : pb[i];
        h[i] = flip ? ha[i] : hb[i];
      end
      rad = flip ? hb[0] : ha[0];
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
        lo = c[i] - h[i];
        hi = c[i] + h[i];
        p = s[i];
        if (p < lo) p = lo;
        if (p > hi) p = hi;
        v[i] = s[i] - p;
        d2 += v[i] * v[i];
      end
      if (d2 <= rad * rad) begin
        hit = 1;
        if (d2 > 0) begin
          dlen = int_sqrt(d2);
          for (int i = 0; i < 3; i++) n[i] = unit_comp(-v[i], dlen);
          pen = rad - dlen;
        end else begin
          // center inside the box: least overlap fallback
          for (int i = 0; i < 3; i++) begin
            d[i] = s[i] - c[i];
            ov[i] = h[i] + rad - labs(d[i]);
          end
          k = 0;
          for (int i = 1; i < 3; i++) if (ov[i] < ov[k]) k = i;
          neg_dir = (d[k] < 0);
          n[k] = neg_dir ? 16384 : -16384;
          pen = ov[k];
        end
      end
      if (flip) for (int i = 0; i < 3; i++) n[i] = -n[i];
    end
    if (!hit) begin
      for (int i = 0; i < 3; i++) n[i] = 0;
      pen = 0;
    end
    if (pen < 0) pen = 0;
    if (pen > 2097151) pen = 2097151;
    r.contact         = hit;
    r.solid_contact   = hit && !b.trigger_a && !b.trigger_b;
    r.trigger_a_fires = hit && b.trigger_a;
    r.trigger_b_fires = hit && b.trigger_b;
    r.normal_x        = n[0][15:0];
    r.normal_y        = n[1][15:0];
    r.normal_z        = n[2][15:0];
    r.penetration     = pen[20:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- driving
  bit sender_idle = 0;   // sender never gaps when set

  // valid stays high from one beat to the next when there is no gap
  task automatic send_pair(npc_pkg::in_beat_t b);
    int gap;
    gap = sender_idle ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    contact_q.push_back(predict_contact(b));
    beats_sent++;
  endtask

  // receiver stall pattern, redrawn per result
  initial begin
    int w;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      w = quiet_out ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // result checker, field by field against the oldest prediction
  always @(posedge clk) begin
    npc_pkg::out_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (contact_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, out_beat);
        errors++;
      end else begin
        e = contact_q.pop_front();
        beats_checked++;
        if (e.contact) hits_seen++;
        if (out_beat.contact !== e.contact) begin
          $display("%0t: contact exp %0b act %0b", $time, e.contact, out_beat.contact);
          errors++;
        end
        if (out_beat.solid_contact !== e.solid_contact) begin
          $display("%0t: solid_contact exp %0b act %0b", $time,
                   e.solid_contact, out_beat.solid_contact);
          errors++;
        end
        if (out_beat.trigger_a_fires !== e.trigger_a_fires) begin
          $display("%0t: trigger_a_fires exp %0b act %0b", $time,
                   e.trigger_a_fires, out_beat.trigger_a_fires);
          errors++;
        end
        if (out_beat.trigger_b_fires !== e.trigger_b_fires) begin
          $display("%0t: trigger_b_fires exp %0b act %0b", $time,
                   e.trigger_b_fires, out_beat.trigger_b_fires);
          errors++;
        end
        if (out_beat.normal_x !== e.normal_x) begin
          $display("%0t: normal_x exp %0d act %0d", $time, e.normal_x, out_beat.normal_x);
          errors++;
        end
        if (out_beat.normal_y !== e.normal_y) begin
          $display("%0t: normal_y exp %0d act %0d", $time, e.normal_y, out_beat.normal_y);
          errors++;
        end
        if (out_beat.normal_z !== e.normal_z) begin
          $display("%0t: normal_z exp %0d act %0d", $time, e.normal_z, out_beat.normal_z);
          errors++;
        end
        if (out_beat.penetration !== e.penetration) begin
          $display("%0t: penetration exp %0d act %0d", $time,
                   e.penetration, out_beat.penetration);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic [59:0] pack_ext(int unsigned x, int unsigned y, int unsigned z);
    return {z[19:0], y[19:0], x[19:0]};
  endfunction

  function automatic npc_pkg::in_beat_t make_pair(int sa, int sb, int ax, int ay, int az,
                                                  int bx, int by, int bz,
                                                  logic [59:0] ea, logic [59:0] eb);
    npc_pkg::in_beat_t b;
    b.shape_a = sa[0]; b.shape_b = sb[0];
    b.trigger_a = 1'($urandom_range(0, 1));
    b.trigger_b = 1'($urandom_range(0, 1));
    b.a_pos_x = ax[23:0]; b.a_pos_y = ay[23:0]; b.a_pos_z = az[23:0];
    b.b_pos_x = bx[23:0]; b.b_pos_y = by[23:0]; b.b_pos_z = bz[23:0];
    b.a_extents = ea; b.b_extents = eb;
    return b;
  endfunction

  // nearby pair with random small sizes, mostly in contact range
  function automatic npc_pkg::in_beat_t near_pair();
    npc_pkg::in_beat_t b;
    int cx, cy, cz, span;
    span = $urandom_range(0, 3) == 0 ? 1 << 20 : 1 << 12;
    cx = $signed($urandom()) >>> 9;
    cy = $signed($urandom()) >>> 9;
    cz = $signed($urandom()) >>> 9;
    b = make_pair($urandom_range(0, 1), $urandom_range(0, 1), cx, cy, cz,
                  cx + $urandom_range(0, 2 * span) - span,
                  cy + $urandom_range(0, 2 * span) - span,
                  cz + $urandom_range(0, 2 * span) - span,
                  pack_ext($urandom_range(0, span), $urandom_range(0, span),
                           $urandom_range(0, span)),
                  pack_ext($urandom_range(0, span), $urandom_range(0, span),
                           $urandom_range(0, span)));
    return b;
  endfunction

  // fully random bits in every field
  function automatic npc_pkg::in_beat_t noise_pair();
    npc_pkg::in_beat_t b;
    b = make_pair($urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  60'({$urandom(), $urandom()}), 60'({$urandom(), $urandom()}));
    return b;
  endfunction

  task automatic test_directed();
    logic [59:0] emax;
    emax = '1;
    // box/box overlap, ties across axes, and separated on one axis
    send_pair(make_pair(0, 0, 0, 0, 0, 100, 0, 0, pack_ext(1024, 1024, 1024),
                        pack_ext(1024, 1024, 1024)));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, pack_ext(512, 512, 512),
                        pack_ext(512, 512, 512)));
    send_pair(make_pair(0, 0, 0, 0, 0, -3000, 10, 5, pack_ext(1024, 2048, 2048),
                        pack_ext(1024, 2048, 2048)));
    send_pair(make_pair(0, 0, 0, 0, 0, 2048, 0, 0, pack_ext(1024, 1024, 1024),
                        pack_ext(1024, 1024, 1024)));
    // sphere/sphere: coincident, touching exactly, overlapping diagonal
    send_pair(make_pair(1, 1, 5, 5, 5, 5, 5, 5, pack_ext(1024, 0, 0), pack_ext(1024, 0, 0)));
    send_pair(make_pair(1, 1, 0, 0, 0, 2048, 0, 0, pack_ext(1024, 0, 0),
                        pack_ext(1024, 0, 0)));
    send_pair(make_pair(1, 1, 0, 0, 0, -700, 900, -300, pack_ext(1024, 7, 9),
                        pack_ext(1024, 3, 1)));
    send_pair(make_pair(1, 1, 0, 0, 0, 0, 0, 0, pack_ext(0, 0, 0), pack_ext(0, 0, 0)));
    // sphere/box: outside touching, closest point on a corner, center inside
    send_pair(make_pair(1, 0, 2048, 0, 0, 0, 0, 0, pack_ext(1024, 0, 0),
                        pack_ext(1024, 1024, 1024)));
    send_pair(make_pair(1, 0, 1500, 1500, 1500, 0, 0, 0, pack_ext(1024, 0, 0),
                        pack_ext(1024, 1024, 1024)));
    send_pair(make_pair(1, 0, -100, 20, 0, 0, 0, 0, pack_ext(300, 0, 0),
                        pack_ext(1024, 1024, 1024)));
    send_pair(make_pair(1, 0, 0, 0, 0, 0, 0, 0, pack_ext(300, 0, 0),
                        pack_ext(1024, 1024, 1024)));
    // box A with sphere B: swapped and negated
    send_pair(make_pair(0, 1, 0, 0, 0, 1800, -200, 0, pack_ext(1024, 1024, 1024),
                        pack_ext(1024, 0, 0)));
    send_pair(make_pair(0, 1, 0, 0, 0, 0, 100, 0, pack_ext(1024, 1024, 1024),
                        pack_ext(50, 0, 0)));
    // extreme positions and extents, penetration saturation
    send_pair(make_pair(0, 0, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                        emax, emax));
    send_pair(make_pair(1, 1, 8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                        emax, emax));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, emax, emax));
    send_pair(make_pair(1, 1, 0, 0, 0, 1, 0, 0, emax, emax));
    send_pair(make_pair(1, 0, -8388608, 8388607, 0, 8388607, -8388608, 0, emax, emax));
    send_pair(make_pair(0, 1, 8388607, 0, -8388608, -8388608, 0, 8388607, emax, emax));
    send_pair(make_pair(1, 1, 0, 0, 0, 0, 0, 0, 60'd0, 60'd0));
  endtask

  task automatic test_random();
    for (int i = 0; i < 730; i++) begin
      if ($urandom_range(0, 4) == 0) send_pair(noise_pair());
      else send_pair(near_pair());
    end
  endtask

  // receiver holds off long while the sender keeps offering back to back
  task automatic test_backpressure();
    sender_idle = 1;
    hold_cycles = 300;
    for (int i = 0; i < 150; i++) send_pair(near_pair());
    sender_idle = 0;
  endtask

  // full rate in both directions
  task automatic test_streaming();
    sender_idle = 1;
    quiet_out = 1;
    for (int i = 0; i < 100; i++) send_pair(near_pair());
    sender_idle = 0;
    quiet_out = 0;
  endtask

  initial begin
    int waited;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_beat  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_streaming();
    test_random();
    in_valid <= 1'b0;
    waited = 0;
    while (contact_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    // drain time past the end of the pipe
    repeat (100) @(posedge clk);
    $display("sent %0d pairs of every shape combination, checked %0d results, %0d in contact",
             beats_sent, beats_checked, hits_seen);
    $display("random stalls, a long receiver hold-off and full-rate streaming were exercised");
    if (errors == 0 && contact_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, contact_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
